>>> design/assert_macros.svh
// Assertion helpers used by positional_list_engine.
// Each macro samples on the rising edge of clk and is muted while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/plist_pkg.sv
`default_nettype none
package plist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_W   = 8;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int COUNT_W = 5;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_INS_AT    = 3'd2;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [2:0] MODE_DEL_AT    = 3'd5;
  localparam logic [2:0] MODE_DUMP      = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] value;
    logic [POS_W-1:0]  position;
  } op_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry;
    logic [COUNT_W-1:0] count;
    logic               last;
  } res_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic             exec;
    logic             emit;
    logic [IDX_W-1:0] idx;
    logic             last;
  } plist_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] last_idx;
  } plist_stat_t;

endpackage
`default_nettype wire

>>> design/plist_ctrl.sv
`default_nettype none
module plist_ctrl import plist_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  mode,
  input  var  plist_stat_t stat,
  output var  plist_cmd_t  cmd,
  output wire logic        busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             dump_go;

  assign dump_go = (mode == MODE_DUMP) && !stat.empty;
  assign busy    = (state == S_DUMP);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (dump_go) begin
            state_next = S_DUMP;
            idx_next   = '0;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_DUMP: begin
        cmd.emit = 1'b1;
        cmd.idx  = idx;
        cmd.last = (idx == stat.last_idx);
        idx_next = idx + 1'b1;
        if (cmd.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule
`default_nettype wire

>>> design/plist_dp.sv
`default_nettype none
module plist_dp import plist_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  var  op_word_t    op,
  input  var  plist_cmd_t  cmd,
  output var  plist_stat_t stat,
  output wire logic        strobe,
  output var  res_word_t   res
);

  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_next [CAPACITY];
  logic [CNT_W-1:0]      length, length_next;
  logic                  strobe_q;
  res_word_t             res_q, res_next;

  logic [CMP_W-1:0]      pos_x, len_x, slot, del_idx;
  logic [DATA_WIDTH-1:0] word;
  logic                  empty, full, do_ins, do_del;
  logic [1:0]            status;

  assign pos_x = CMP_W'(op.position);
  assign len_x = CMP_W'(length);
  assign empty = (length == '0);
  assign full  = (length == CNT_W'(CAPACITY));
  assign word  = DATA_WIDTH'(op.value);

  assign stat.empty    = empty;
  assign stat.last_idx = IDX_W'(length - 1'b1);

  // Operation decode: pick the slot to open or close and the status.
  always_comb begin
    slot    = '0;
    del_idx = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    status  = ST_OK;
    unique case (op.mode) inside
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
        if (op.mode == MODE_INS_BACK) begin
          slot = len_x;
        end else if (op.mode == MODE_INS_AT && pos_x != CMP_W'(1) && !empty) begin
          slot = (pos_x >= CMP_W'(2)) ? pos_x - 1'b1 : CMP_W'(1);
          if (slot > len_x) begin
            slot = len_x;
          end
        end
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
        if (op.mode == MODE_DEL_BACK) begin
          del_idx = len_x - 1'b1;
        end else if (op.mode == MODE_DEL_AT) begin
          del_idx = pos_x - 1'b1;
        end
        if (empty) begin
          status = ST_EMPTY;
        end else if (op.mode == MODE_DEL_AT &&
                     (pos_x < CMP_W'(1) || pos_x > len_x)) begin
          status = ST_INVALID;
        end else begin
          do_del = 1'b1;
        end
      end
      MODE_DUMP: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Every cell looks only at itself and its two neighbors.
  always_comb begin
    length_next = length;
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (cmd.exec && do_ins) begin
        if (CMP_W'(i) == slot) begin
          cells_next[i] = word;
        end else if (CMP_W'(i) > slot && i > 0) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && do_del) begin
        if (CMP_W'(i) >= del_idx && i < CAPACITY - 1) begin
          cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
    if (cmd.exec && do_ins) begin
      length_next = length + 1'b1;
    end else if (cmd.exec && do_del) begin
      length_next = length - 1'b1;
    end
  end

  always_comb begin
    res_next = res_q;
    if (cmd.emit) begin
      res_next.status = ST_OK;
      res_next.entry  = 32'($signed(cells[cmd.idx]));
      res_next.count  = COUNT_W'(length);
      res_next.last   = cmd.last;
    end else if (cmd.exec) begin
      res_next.status = status;
      res_next.entry  = '0;
      res_next.count  = COUNT_W'(length_next);
      res_next.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
    res_q <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      strobe_q <= 1'b0;
    end else begin
      length   <= length_next;
      strobe_q <= cmd.exec || cmd.emit;
    end
  end

  assign strobe = strobe_q;
  assign res    = res_q;

endmodule
`default_nettype wire

>>> design/positional_list_engine.sv
// Channel   Handshake                Payload     Moves
// -------   ----------------------   ---------   ------------------------------
// op        start, busy (in: busy)   op_word     one operation word per accept
// res       strobe                   res_word    one result word per strobe
//
// Any word but a dump of a non-empty list is accepted with start high and busy
// low, and its one result word is on the port with strobe in the next cycle.
// A dump of n entries runs through the accept, then one cell read per
// entry; busy stays high until the last word is on the port.
// Reset is synchronous and clears the length, the controller and the strobe;
// the cells keep whatever they held. The receiver cannot stall the results.
`default_nettype none
`include "assert_macros.svh"
module positional_list_engine import plist_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output wire logic      busy,
  input  var  op_word_t  op_word,
  output wire logic      strobe,
  output var  res_word_t res_word
);

  plist_cmd_t  cmd;
  plist_stat_t stat;

  // The controller sequences dumps and grants every other operation.
  plist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (op_word.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the cells, the length and the result register.
  plist_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op_word),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .res    (res_word)
  );

  // A word that closes an operation always leaves the block free again.
  `ASSERT_NOW(a_last_frees, strobe && res_word.last, !busy)
  // A dump word that is not the last one keeps the block busy.
  `ASSERT_NOW(a_mid_busy, strobe && !res_word.last, busy)
  // Anything other than a dump answers with its one word right after accept.
  `ASSERT_NEXT(a_single_word, start && !busy && op_word.mode != MODE_DUMP,
               strobe && res_word.last)
  // A full flag reports the list at capacity.
  `ASSERT_NOW(a_full_count, strobe && res_word.status == ST_FULL,
              res_word.count == COUNT_W'(CAPACITY))

endmodule
`default_nettype wire
